/* src/sipfp_pkg.sv */
// ----------------------------------------------------------------------------
// sipfp_pkg
// Shared types and constants of the dual-key SipHash-2-4 fingerprint block.
// ----------------------------------------------------------------------------
package sipfp_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned LenW   = 8;
  localparam int unsigned CfgW   = 1;

  localparam logic [WordW-1:0] SipC0      = 64'h736f_6d65_7073_6575;
  localparam logic [WordW-1:0] SipC1      = 64'h646f_7261_6e64_6f6d;
  localparam logic [WordW-1:0] SipC2      = 64'h6c79_6765_6e65_7261;
  localparam logic [WordW-1:0] SipC3      = 64'h7465_6462_7974_6573;
  localparam logic [WordW-1:0] LaneBMask0 = 64'ha5a5_a5a5_a5a5_a5a5;
  localparam logic [WordW-1:0] LaneBMask1 = 64'h5a5a_5a5a_5a5a_5a5a;
  localparam logic [WordW-1:0] FinalXor   = 64'h0000_0000_0000_00ff;
  localparam int unsigned      LenShift   = 56;
  localparam logic [CountW-1:0] FullCount = 4'd8;

  localparam logic [CfgW-1:0] RegKeyWord0 = 1'b0;
  localparam logic [CfgW-1:0] RegKeyWord1 = 1'b1;

  typedef logic [3:0][WordW-1:0] sipfp_vec_t;

  typedef enum logic [2:0] {
    StIdle,
    StAbs2,
    StTail1,
    StTail2,
    StFinal,
    StEmit
  } sipfp_state_e;

  typedef struct packed {
    logic load;
    logic pre3;
    logic rnd;
    logic post0;
    logic post3;
    logic fin;
  } sipfp_lane_cmd_t;

endpackage

/* src/sipfp_lane.sv */
// ----------------------------------------------------------------------------
// sipfp_lane
// One SipHash lane: state words v0..v3 and a single SipRound unit that is
// reused every cycle under command of the sequencer.
// ----------------------------------------------------------------------------
module sipfp_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sipfp_pkg::sipfp_lane_cmd_t cmd_i,
  input  logic [sipfp_pkg::WordW-1:0] key0_i,
  input  logic [sipfp_pkg::WordW-1:0] key1_i,
  input  logic [sipfp_pkg::WordW-1:0] m0_i,
  input  logic [sipfp_pkg::WordW-1:0] m3_i,
  output logic [sipfp_pkg::WordW-1:0] digest_o
);
  import sipfp_pkg::*;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (WordW - r));
  endfunction

  function automatic sipfp_vec_t sip_round(input sipfp_vec_t vi);
    logic [WordW-1:0] a0, a1, a2, a3;
    a0 = vi[0];
    a1 = vi[1];
    a2 = vi[2];
    a3 = vi[3];
    a0 = a0 + a1; a1 = rotl(a1, 13); a1 = a1 ^ a0; a0 = rotl(a0, 32);
    a2 = a2 + a3; a3 = rotl(a3, 16); a3 = a3 ^ a2;
    a0 = a0 + a3; a3 = rotl(a3, 21); a3 = a3 ^ a0;
    a2 = a2 + a1; a1 = rotl(a1, 17); a1 = a1 ^ a2; a2 = rotl(a2, 32);
    sip_round = {a3, a2, a1, a0};
  endfunction

  sipfp_vec_t v_q, v_d;
  sipfp_vec_t base, rnd_out;

  always_comb begin
    if (cmd_i.load) begin
      base[0] = key0_i ^ SipC0;
      base[1] = key1_i ^ SipC1;
      base[2] = key0_i ^ SipC2;
      base[3] = key1_i ^ SipC3;
    end else begin
      base = v_q;
    end
    if (cmd_i.pre3) begin
      base[3] = base[3] ^ m3_i;
    end
    rnd_out = sip_round(base);
    v_d = cmd_i.rnd ? rnd_out : base;
    if (cmd_i.post0) begin
      v_d[0] = v_d[0] ^ m0_i;
    end
    if (cmd_i.post3) begin
      v_d[3] = v_d[3] ^ m3_i;
    end
    if (cmd_i.fin) begin
      v_d[2] = v_d[2] ^ FinalXor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign digest_o = v_q[0] ^ v_q[1] ^ v_q[2] ^ v_q[3];

endmodule

/* src/siphash24_dual_key_fingerprint.sv */
// ----------------------------------------------------------------------------
// siphash24_dual_key_fingerprint
// Two SipHash-2-4 digests of one byte stream, under the plain and the
// xor-modified key, emitted together on the last word of a message.
// ----------------------------------------------------------------------------
// Each lane has one SipRound unit that runs one round per cycle. A word that
// is not last passes StIdle and StAbs2. A last word with fewer than eight
// bytes goes on to StFinal, one with eight or more to StTail1, StTail2 and
// StFinal, until StEmit loads the digests into the result register; the block
// takes no new beat during that time. A finished result waits in its own
// register, so the next message can start while it is still stalled.
module siphash24_dual_key_fingerprint (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sipfp_pkg::CfgW-1:0]   cfg_addr_i,
  input  logic [sipfp_pkg::WordW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sipfp_pkg::WordW-1:0]  message_word_i,
  input  logic [sipfp_pkg::CountW-1:0] byte_count_i,
  input  logic                        last_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sipfp_pkg::WordW-1:0]  digest_lane_a_o,
  output logic [sipfp_pkg::WordW-1:0]  digest_lane_b_o
);
  import sipfp_pkg::*;

  sipfp_state_e     state_q, state_d;
  logic [1:0]       rnd_cnt_q, rnd_cnt_d;
  logic [WordW-1:0] key0_q, key1_q;
  logic [WordW-1:0] msg_q, tail_q;
  logic             full_q, last_q;
  logic [LenW-1:0]  len_q;
  logic             open_q;
  logic             out_valid_q;
  logic [WordW-1:0] dig_a_q, dig_b_q;

  logic             in_acc;
  logic             out_free;
  logic [CountW-1:0] cnt_sat;
  logic             full_new;
  logic [LenW-1:0]  len_new;
  logic [WordW-1:0] masked;
  logic [WordW-1:0] tail_new;
  logic [WordW-1:0] m0, m3;
  logic             out_load;
  sipfp_lane_cmd_t  cmd;
  logic [WordW-1:0] dig_a, dig_b;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // length tail of the current beat
  always_comb begin
    cnt_sat  = (byte_count_i > FullCount) ? FullCount : byte_count_i;
    full_new = !last_word_i || (byte_count_i >= FullCount);
    len_new  = (open_q ? len_q : '0) + (full_new ? LenW'(FullCount) : LenW'(cnt_sat));
    for (int j = 0; j < 8; j++) begin
      masked[j*8 +: 8] = (j < int'(cnt_sat)) ? message_word_i[j*8 +: 8] : 8'h00;
    end
    tail_new = ({{(WordW-LenW){1'b0}}, len_new} << LenShift)
             | (full_new ? '0 : masked);
  end

  // next state
  always_comb begin
    state_d   = state_q;
    rnd_cnt_d = rnd_cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StAbs2;
        end
      end
      StAbs2: begin
        rnd_cnt_d = '0;
        if (!last_q) begin
          state_d = StIdle;
        end else if (full_q) begin
          state_d = StTail1;
        end else begin
          state_d = StFinal;
        end
      end
      StTail1: begin
        state_d = StTail2;
      end
      StTail2: begin
        rnd_cnt_d = '0;
        state_d   = StFinal;
      end
      StFinal: begin
        rnd_cnt_d = rnd_cnt_q + 2'd1;
        if (rnd_cnt_q == 2'd3) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd        = '0;
    m0         = msg_q;
    m3         = tail_q;
    out_load   = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        m3         = full_new ? message_word_i : tail_new;
        if (in_valid_i) begin
          cmd.load = !open_q;
          cmd.pre3 = 1'b1;
          cmd.rnd  = 1'b1;
        end
      end
      StAbs2: begin
        cmd.rnd   = 1'b1;
        cmd.post0 = 1'b1;
        cmd.post3 = last_q && full_q;
        cmd.fin   = last_q && !full_q;
      end
      StTail1: begin
        cmd.rnd = 1'b1;
      end
      StTail2: begin
        m0        = tail_q;
        cmd.rnd   = 1'b1;
        cmd.post0 = 1'b1;
        cmd.fin   = 1'b1;
      end
      StFinal: begin
        cmd.rnd = 1'b1;
      end
      StEmit: begin
        out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  sipfp_lane u_lane_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .key0_i   (key0_q),
    .key1_i   (key1_q),
    .m0_i     (m0),
    .m3_i     (m3),
    .digest_o (dig_a)
  );

  sipfp_lane u_lane_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .key0_i   (key0_q ^ LaneBMask0),
    .key1_i   (key1_q ^ LaneBMask1),
    .m0_i     (m0),
    .m3_i     (m3),
    .digest_o (dig_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rnd_cnt_q   <= '0;
      key0_q      <= '0;
      key1_q      <= '0;
      len_q       <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
      full_q      <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      rnd_cnt_q <= rnd_cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegKeyWord0: key0_q <= cfg_wdata_i;
          RegKeyWord1: key1_q <= cfg_wdata_i;
          default:     key0_q <= key0_q;
        endcase
      end
      if (in_acc) begin
        len_q  <= len_new;
        open_q <= !last_word_i;
        full_q <= full_new;
        last_q <= last_word_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      msg_q  <= full_new ? message_word_i : tail_new;
      tail_q <= tail_new;
    end
    if (out_load) begin
      dig_a_q <= dig_a;
      dig_b_q <= dig_b;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign digest_lane_a_o = dig_a_q;
  assign digest_lane_b_o = dig_b_q;

  a_word_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !last_word_i |=> ##1 state_q == StIdle)
    else $error("non-last word did not finish in two cycles");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(state_q) == StEmit)
    else $error("result register loaded outside emit");

  a_final_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFinal && rnd_cnt_q == 2'd3 |=> state_q == StEmit)
    else $error("finalization did not end after four rounds");

endmodule

/* test/tb_siphash24_dual_key_fingerprint.sv */
// ----------------------------------------------------------------------------
// tb_siphash24_dual_key_fingerprint
// Self-checking testbench of the dual-key SipHash-2-4 fingerprint block.
// A queue of message words feeds a clocked driver. An independent SipHash-2-4
// predictor folds every accepted word and predicts both digests of each
// finished message, and the output monitor compares them field by field.
// Both sides idle at random, the receiver holds off once for a long stretch,
// and the keys change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_siphash24_dual_key_fingerprint;
  timeunit 1ns;
  timeprecision 1ps;

  import sipfp_pkg::*;

  localparam int unsigned PhaseItems = 250;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned DrainWait  = 16;
  localparam int unsigned HoldAt     = 150;
  localparam int unsigned HoldLen    = 400;

  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [CountW-1:0] count;
    logic              last;
  } msg_beat_t;

  typedef struct packed {
    logic [WordW-1:0] lane_a;
    logic [WordW-1:0] lane_b;
  } digest_pair_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [CfgW-1:0]    cfg_addr_i     = RegKeyWord0;
  logic [WordW-1:0]   cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [WordW-1:0]   message_word_i = '0;
  logic [CountW-1:0]  byte_count_i   = '0;
  logic               last_word_i    = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [WordW-1:0]   digest_lane_a_o;
  logic [WordW-1:0]   digest_lane_b_o;

  msg_beat_t    beat_q[$];
  digest_pair_t digest_q[$];
  int unsigned  err_cnt = 0;

  // predictor state
  logic [WordW-1:0] key0_shadow = '0;
  logic [WordW-1:0] key1_shadow = '0;
  sipfp_vec_t       lane_a_v;
  sipfp_vec_t       lane_b_v;
  logic [LenW-1:0]  msg_len  = '0;
  logic             msg_open = 1'b0;

  siphash24_dual_key_fingerprint DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .message_word_i (message_word_i),
    .byte_count_i   (byte_count_i),
    .last_word_i    (last_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digest_lane_a_o(digest_lane_a_o),
    .digest_lane_b_o(digest_lane_b_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [WordW-1:0] rol(logic [WordW-1:0] x, int unsigned r);
    return (x << r) | (x >> (WordW - r));
  endfunction

  function automatic sipfp_vec_t sip_mix(sipfp_vec_t v);
    v[0] = v[0] + v[1]; v[1] = rol(v[1], 13); v[1] ^= v[0]; v[0] = rol(v[0], 32);
    v[2] = v[2] + v[3]; v[3] = rol(v[3], 16); v[3] ^= v[2];
    v[0] = v[0] + v[3]; v[3] = rol(v[3], 21); v[3] ^= v[0];
    v[2] = v[2] + v[1]; v[1] = rol(v[1], 17); v[1] ^= v[2]; v[2] = rol(v[2], 32);
    return v;
  endfunction

  function automatic sipfp_vec_t lane_seed(logic [WordW-1:0] k0, logic [WordW-1:0] k1);
    sipfp_vec_t v;
    v[0] = k0 ^ SipC0;
    v[1] = k1 ^ SipC1;
    v[2] = k0 ^ SipC2;
    v[3] = k1 ^ SipC3;
    return v;
  endfunction

  function automatic sipfp_vec_t lane_compress(sipfp_vec_t v, logic [WordW-1:0] m);
    v[3] ^= m;
    v = sip_mix(sip_mix(v));
    v[0] ^= m;
    return v;
  endfunction

  function automatic logic [WordW-1:0] lane_digest(sipfp_vec_t v, logic [WordW-1:0] tail);
    v = lane_compress(v, tail);
    v[2] ^= FinalXor;
    for (int i = 0; i < 4; i++) v = sip_mix(v);
    return v[0] ^ v[1] ^ v[2] ^ v[3];
  endfunction

  // folds one accepted beat, queues both digests when the message closes
  task automatic fold_beat(msg_beat_t b);
    logic [WordW-1:0] tail;
    logic [WordW-1:0] ones;
    digest_pair_t     d;
    ones = '1;
    tail = '0;
    if (!msg_open) begin
      lane_a_v = lane_seed(key0_shadow, key1_shadow);
      lane_b_v = lane_seed(key0_shadow ^ LaneBMask0, key1_shadow ^ LaneBMask1);
      msg_len  = '0;
      msg_open = 1'b1;
    end
    if (!b.last || b.count >= FullCount) begin
      lane_a_v = lane_compress(lane_a_v, b.word);
      lane_b_v = lane_compress(lane_b_v, b.word);
      msg_len  = msg_len + 8'd8;
    end else begin
      if (b.count != '0) tail = b.word & (ones >> (WordW - 8 * b.count));
      msg_len = msg_len + LenW'(b.count);
    end
    if (b.last) begin
      tail = tail | ({{(WordW-LenW){1'b0}}, msg_len} << LenShift);
      d.lane_a = lane_digest(lane_a_v, tail);
      d.lane_b = lane_digest(lane_b_v, tail);
      digest_q.push_back(d);
      msg_open = 1'b0;
    end
  endtask

  // driver
  int unsigned sent_cnt = 0;
  always @(posedge clk_i) begin
    msg_beat_t b;
    logic      gap;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sent_cnt++;
      if (!in_valid_i || !in_stall_o) begin
        gap = (sent_cnt >= 800 && sent_cnt < 1100) ? 1'b0 : ($urandom_range(0, 99) < 25);
        if (beat_q.size() != 0 && !gap) begin
          b = beat_q.pop_front();
          in_valid_i     <= 1'b1;
          message_word_i <= b.word;
          byte_count_i   <= b.count;
          last_word_i    <= b.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // input monitor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      fold_beat('{word: message_word_i, count: byte_count_i, last: last_word_i});
  end

  // receiver and result check
  int unsigned results_seen = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;
  always @(posedge clk_i) begin
    digest_pair_t d;
    logic         stall;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (digest_q.size() == 0) begin
          $error("unexpected digest beat: lane_a %h lane_b %h", digest_lane_a_o,
                 digest_lane_b_o);
          err_cnt++;
        end else begin
          d = digest_q.pop_front();
          if (digest_lane_a_o !== d.lane_a) begin
            $error("digest_lane_a: expected %h, actual %h", d.lane_a, digest_lane_a_o);
            err_cnt++;
          end
          if (digest_lane_b_o !== d.lane_b) begin
            $error("digest_lane_b: expected %h, actual %h", d.lane_b, digest_lane_b_o);
            err_cnt++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (!hold_done && results_seen >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldLen;
        stall     = 1'b1;
      end else if (results_seen >= 230 && results_seen < 330) begin
        stall = 1'b0;
      end else begin
        stall = $urandom_range(0, 99) < 25;
      end
      out_stall_i <= stall;
    end
  end

  // watchdog
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("siphash24_dual_key_fingerprint regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [WordW-1:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '1;
    if (r < 20) return '0;
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_beat(logic [WordW-1:0] w, logic [CountW-1:0] c, logic l);
    beat_q.push_back('{word: w, count: c, last: l});
  endtask

  task automatic push_message(int unsigned n_words);
    logic [CountW-1:0] c;
    for (int unsigned i = 1; i < n_words; i++) begin
      c = ($urandom_range(0, 99) < 80) ? FullCount : CountW'($urandom_range(0, 15));
      push_beat(rand_word(), c, 1'b0);
    end
    c = ($urandom_range(0, 99) < 85) ? CountW'($urandom_range(0, 8))
                                     : CountW'($urandom_range(9, 15));
    push_beat(rand_word(), c, 1'b1);
  endtask

  task automatic write_key(logic [CfgW-1:0] idx, logic [WordW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    if (idx == RegKeyWord0) key0_shadow = value;
    else key1_shadow = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender pauses here until every digest has come back
  task automatic drain_results();
    do @(negedge clk_i);
    while (beat_q.size() != 0 || in_valid_i || digest_q.size() != 0);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  initial begin
    logic [WordW-1:0] k0;
    logic [WordW-1:0] k1;
    int unsigned      r;
    int unsigned      phase_start;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed messages under the reset keys
    push_beat({$urandom(), $urandom()}, 4'd0, 1'b1);
    push_beat('1, FullCount, 1'b1);
    push_beat('1, 4'd3, 1'b1);
    push_beat('0, 4'd15, 1'b1);
    push_beat({$urandom(), $urandom()}, 4'd9, 1'b1);
    push_beat('1, 4'd0, 1'b0);
    push_beat('0, 4'd15, 1'b0);
    push_beat({$urandom(), $urandom()}, 4'd7, 1'b1);
    push_beat({$urandom(), $urandom()}, FullCount, 1'b0);
    push_beat({$urandom(), $urandom()}, FullCount, 1'b1);
    for (int c = 1; c < 7; c++) push_beat('1, CountW'(c), 1'b1);
    push_beat(64'h0123_4567_89ab_cdef, 4'd12, 1'b1);
    drain_results();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          k0 = '1; k1 = '1;
        end
        1: begin
          k0 = LaneBMask0; k1 = LaneBMask1;
        end
        2: begin
          k0 = '0; k1 = '0;
        end
        3: begin
          k0 = '1; k1 = '0;
        end
        default: begin
          k0 = {$urandom(), $urandom()}; k1 = {$urandom(), $urandom()};
        end
      endcase
      write_key(RegKeyWord0, k0);
      write_key(RegKeyWord1, k1);
      phase_start = beat_q.size();
      while (beat_q.size() - phase_start < PhaseItems) begin
        r = $urandom_range(0, 99);
        if (r < 5) push_message($urandom_range(33, 40));
        else if (r < 30) push_message(1);
        else push_message($urandom_range(2, 6));
      end
      // leave a message open across the key change
      if (p % 2 == 1 && p + 1 < NumPhases) begin
        push_beat(rand_word(), FullCount, 1'b0);
        push_beat(rand_word(), CountW'($urandom_range(0, 15)), 1'b0);
      end
      drain_results();
    end

    if (digest_q.size() != 0) begin
      $error("%0d digests never arrived", digest_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("siphash24_dual_key_fingerprint regression: pass");
    end else begin
      $display("siphash24_dual_key_fingerprint regression: fail");
    end
    $finish;
  end

endmodule
